/* design/mpq_pkg.sv */
// Shared constants, codes and control structs for the max priority queue.
package mpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEL_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INS_FULL   = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic start;      // item accepted: latch it, update count, issue first read
    logic ins_step;   // one slide/place step of an insert
    logic latch_max;  // capture read data as the removed maximum
    logic load_out;   // move finished result into the output register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic ins_done;   // current insert step places the value
    logic out_free;   // output register can take a result this cycle
  } dp_sts_t;

endpackage

/* design/mpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mpq_datapath.sv */
// Datapath: sorted entry store, count, working registers and result register.
module mpq_datapath
  import mpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_sts_t                    sts,
  input  logic                       in_command,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [VALUE_W-1:0]  out_max_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_now_empty,
  output logic [OCC_W-1:0]           out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic signed [VALUE_W-1:0] res_r, res_nxt;
  logic [STATUS_W-1:0]       stat_r, stat_nxt;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_max_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_empty_r;
  logic [OCC_W-1:0]          out_occ_r;

  logic                      full, empty, slide;
  logic [CNT_W-1:0]          cnt_m1;
  logic [IDX_W-1:0]          idx_m2;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic signed [VALUE_W-1:0] ram_wdata, ram_rdata;

  assign full   = (count_r >= CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign cnt_m1 = count_r - 1'b1;
  assign idx_m2 = idx_r - IDX_W'(2);

  // Slide the entry below the hole up while it is larger than the new value
  assign slide = (idx_r != '0) && (ram_rdata > val_r);

  assign sts.full     = full;
  assign sts.empty    = empty;
  assign sts.ins_done = !slide;
  assign sts.out_free = !out_valid_r || out_ready;

  // Store port control
  assign ram_we    = cmd.ins_step;
  assign ram_waddr = idx_r;
  assign ram_wdata = slide ? ram_rdata : val_r;
  assign ram_raddr = cmd.start ? cnt_m1[IDX_W-1:0] : idx_m2;

  mpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state of working registers
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    if (cmd.start) begin
      val_nxt = in_value;
      res_nxt = '0;
      idx_nxt = count_r[IDX_W-1:0];
      if (in_command == CMD_INSERT) begin
        if (full) begin
          stat_nxt = ST_INS_FULL;
        end else begin
          stat_nxt  = ST_OK;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          stat_nxt = ST_DEL_EMPTY;
        end else begin
          stat_nxt  = ST_OK;
          count_nxt = cnt_m1;
        end
      end
    end
    if (cmd.ins_step && slide) begin
      idx_nxt = idx_r - 1'b1;
    end
    if (cmd.latch_max) begin
      res_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_max_r    <= res_r;
      out_status_r <= stat_r;
      out_empty_r  <= empty;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_r;
  assign out_status    = out_status_r;
  assign out_now_empty = out_empty_r;
  assign out_occupancy = out_occ_r;

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // An accepted insert into a non-full queue grows the count by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && in_command == CMD_INSERT && !full) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow count");

  // Refused items leave the count alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && ((in_command == CMD_INSERT && full) || (in_command == CMD_DELETE && empty)))
      |=> $stable(count_r))
    else $error("refused item changed count");

endmodule

/* design/mpq_ctrl.sv */
// Controller: sequences accept, insert slide, delete read and result hand-off.
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_command,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          if (in_command == CMD_INSERT && !sts.full) begin
            state_nxt = S_INS;
          end else if (in_command == CMD_DELETE && !sts.empty) begin
            state_nxt = S_DEL;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts.ins_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_DEL: begin
        cmd.latch_max = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Delete work is always followed directly by the result hand-off
  a_del_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL) |=> (state_r == S_EMIT))
    else $error("delete did not move to emit");

  // Only one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // Every accepted item leaves idle
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted item not started");

endmodule

/* design/max_priority_queue_unit.sv */
// Top level of the max priority queue: controller plus datapath.
// Max priority queue of signed 32-bit values held in ascending order in a
// CAPACITY-deep RAM, one item in flight at a time. A delete-max steps through
// accept, RAM read and result hand-off; a refused item (delete when empty,
// insert when full) goes from accept straight to hand-off. An insert steps
// through accept, one slide per stored entry larger than the new value (at
// most CAPACITY - 1), a place step and hand-off, one slot per cycle through
// the RAM's single read and write port. A result that is not taken holds the
// block in hand-off until out_ready; no reset pass is needed on the store.
module max_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_max_value,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_now_empty,
  output logic [OCC_W-1:0]          out_occupancy
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_max_value (out_max_value),
    .out_status    (out_status),
    .out_now_empty (out_now_empty),
    .out_occupancy (out_occupancy)
  );

endmodule

/* test/max_priority_queue_unit_tb.sv */
// Self-checking testbench for the max priority queue unit, with a sorted-list predictor.
`timescale 1ns / 100ps

module max_priority_queue_unit_tb
  import mpq_pkg::*;
();

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int DRAIN_WAIT  = 40;     // covers the longest insert plus hand-off
  localparam int REPORT_MAX  = 10;

  // One predicted result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [STATUS_W-1:0]       status;
    logic                      now_empty;
    logic [OCC_W-1:0]          occupancy;
  } pq_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_command;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_max_value;
  logic [STATUS_W-1:0]       out_status;
  logic                      out_now_empty;
  logic [OCC_W-1:0]          out_occupancy;

  // Predictor state: stored values in ascending signed order
  logic signed [VALUE_W-1:0] sorted_vals[$];
  pq_result_t                pending_results[$];

  int  mismatch_count = 0;
  int  stall_cycles   = 0;
  bit  calm           = 1'b0;   // no idling on either side while set

  max_priority_queue_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_value (out_max_value),
    .out_status    (out_status),
    .out_now_empty (out_now_empty),
    .out_occupancy (out_occupancy)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // Apply one accepted item to the predicted queue and return its result
  function automatic pq_result_t queue_step(input logic cmd,
                                            input logic signed [VALUE_W-1:0] val);
    pq_result_t r;
    int         pos;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (sorted_vals.size() >= DEPTH) begin
        r.status = ST_INS_FULL;
      end else begin
        pos = sorted_vals.size();
        while (pos > 0 && sorted_vals[pos-1] > val) pos--;
        sorted_vals.insert(pos, val);
      end
    end else begin
      if (sorted_vals.size() == 0) begin
        r.status = ST_DEL_EMPTY;
      end else begin
        r.max_value = sorted_vals.pop_back();
      end
    end
    r.now_empty = (sorted_vals.size() == 0);
    r.occupancy = OCC_W'(sorted_vals.size());
    return r;
  endfunction

  // Predict on every accepted item, compare every accepted result
  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_results.push_back(queue_step(in_command, in_value));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected result max=%0d status=%0d empty=%0b occ=%0d", $time,
                     out_max_value, out_status, out_now_empty, out_occupancy);
        end else begin
          want = pending_results.pop_front();
          if (out_max_value !== want.max_value || out_status !== want.status ||
              out_now_empty !== want.now_empty || out_occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display({"%0t: mismatch exp max=%0d status=%0d empty=%0b occ=%0d,",
                        " got max=%0d status=%0d empty=%0b occ=%0d"},
                       $time, want.max_value, want.status, want.now_empty, want.occupancy,
                       out_max_value, out_status, out_now_empty, out_occupancy);
          end
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[max_priority_queue_unit] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Values biased toward extremes and near-zero duplicates
  function automatic logic signed [VALUE_W-1:0] pick_value();
    unique case ($urandom_range(9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return $signed(32'($urandom_range(7))) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Present one item and hold it until it is accepted
  task automatic send_item(input logic cmd, input logic signed [VALUE_W-1:0] val);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random command with a given share of inserts; deletes carry junk values
  task automatic send_random(input int insert_pct);
    if ($urandom_range(99) < insert_pct) send_item(CMD_INSERT, pick_value());
    else                                 send_item(CMD_DELETE, $signed($urandom));
  endtask

  // Extremes, duplicates, delete when empty, insert when full
  task automatic test_directed();
    send_item(CMD_DELETE, 32'sh7FFFFFFF);
    send_item(CMD_INSERT, 32'sh7FFFFFFF);
    send_item(CMD_INSERT, 32'sh80000000);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd1);
    send_item(CMD_INSERT, 32'sh7FFFFFFF);
    for (int k = 6; k < DEPTH; k++) send_item(CMD_INSERT, $signed($urandom));
    send_item(CMD_INSERT, 32'sh55555555);
    repeat (5) send_item(CMD_DELETE, 32'sd0);
  endtask

  // Balanced random traffic
  task automatic test_random_mix();
    repeat (500) send_random(50);
  endtask

  // Repeated fill past full and drain past empty
  task automatic test_fill_drain();
    repeat (12) begin
      repeat ($urandom_range(DEPTH - 2, DEPTH + 3)) send_random(90);
      repeat ($urandom_range(DEPTH - 2, DEPTH + 3)) send_random(10);
    end
  endtask

  // Insert-heavy traffic that sits near full
  task automatic test_insert_heavy();
    repeat (300) send_random(70);
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (250) send_random(50);
    calm = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_INSERT;
    in_value   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix();
    test_fill_drain();
    test_insert_heavy();
    test_back_to_back();

    // Drain: let the last item reach the predictor, wait for every result, then wait out DRAIN_WAIT
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[max_priority_queue_unit] OK");
    end else begin
      $display("[max_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
